FILE: hdl/clm_pkg.sv
// ----------------------------------------------------------------------------
// clm_pkg
// shared constants, item types and grid arithmetic of the 3d color table mapper
// ----------------------------------------------------------------------------
`default_nettype none

package clm_pkg;

    // grid geometry; both counts are powers of two so tiles index by bit fields
    localparam int STEPS     = 64;
    localparam int TILES     = 8;
    localparam int STEP_W    = $clog2(STEPS);
    localparam int TILE_W    = $clog2(TILES);
    localparam int ROW_W     = STEP_W + TILE_W;

    localparam int CH_W      = 8;
    localparam int NUM_CH    = 3;
    localparam int PIX_W     = CH_W * NUM_CH;
    localparam int ADDR_W    = 18;
    localparam int GRID_T_W  = CH_W + STEP_W;
    localparam int SUM_W     = 2 * CH_W;

    localparam logic [CH_W-1:0]   CH_MAX    = 8'hFF;
    localparam logic [STEP_W-1:0] GRID_LAST = STEP_W'(STEPS - 1);

    // channel slots inside a pixel vector
    localparam int CH_RED   = 2;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 0;

    // operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_MAP  = 1'b1;

    // configuration registers
    localparam int PADDR_W   = 3;
    localparam int REG_IDX_W = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_LUT_ENABLE = '0;

    typedef logic [NUM_CH-1:0][CH_W-1:0] t_pixel;

    typedef struct packed {
        logic              operation;
        logic [ADDR_W-1:0] entry_index;
        logic [CH_W-1:0]   red_in;
        logic [CH_W-1:0]   green_in;
        logic [CH_W-1:0]   blue_in;
    } t_in_item;

    typedef struct packed {
        logic [CH_W-1:0] red_out;
        logic [CH_W-1:0] green_out;
        logic [CH_W-1:0] blue_out;
    } t_out_item;

    typedef struct packed {
        logic [STEP_W-1:0] lo;
        logic [STEP_W-1:0] hi;
        logic [CH_W-1:0]   m;
    } t_grid;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  data;
    } t_wr_req;

    // x / 255 for x below 65280, by reciprocal with correction
    function automatic logic [CH_W-1:0] div255(input logic [SUM_W-1:0] x);
        logic [SUM_W:0] s;
        s = {1'b0, x} + (SUM_W+1)'(1) + {{(CH_W+1){1'b0}}, x[SUM_W-1:CH_W]};
        return s[SUM_W-1:CH_W];
    endfunction

    // grid cell and weight numerator of one channel
    function automatic t_grid grid_of(input logic [CH_W-1:0] v);
        logic [GRID_T_W-1:0] t;
        logic [CH_W-1:0]     q;
        logic [GRID_T_W-1:0] lo_x;
        logic [GRID_T_W-1:0] m_full;
        t_grid               g;
        t = GRID_T_W'(v) << STEP_W;
        q = div255(SUM_W'(t));
        g.lo = (q > CH_W'(GRID_LAST)) ? GRID_LAST : q[STEP_W-1:0];
        g.hi = (g.lo == GRID_LAST) ? g.lo : g.lo + STEP_W'(1);
        lo_x = GRID_T_W'(g.lo);
        m_full = t - ((lo_x << CH_W) - lo_x);
        g.m = (m_full > GRID_T_W'(CH_MAX)) ? CH_MAX : m_full[CH_W-1:0];
        return g;
    endfunction

    // tiled address: row = (b / T) * S + g, column = (b % T) * S + r
    function automatic logic [ADDR_W-1:0] lut_addr(input logic [STEP_W-1:0] r,
                                                   input logic [STEP_W-1:0] g,
                                                   input logic [STEP_W-1:0] b);
        logic [31:0] row;
        logic [31:0] col;
        logic [31:0] idx;
        row = ((32'(b) >> TILE_W) << STEP_W) | 32'(g);
        col = ((32'(b) & 32'(TILES - 1)) << STEP_W) | 32'(r);
        idx = (row << ROW_W) | col;
        return idx[ADDR_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: hdl/clm_if.sv
// ----------------------------------------------------------------------------
// clm_if
// valid/ready item channels into and out of the color table mapper
// ----------------------------------------------------------------------------
`default_nettype none

interface clm_in_if;
    logic              valid;
    logic              ready;
    clm_pkg::t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface clm_out_if;
    logic               valid;
    logic               ready;
    clm_pkg::t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: hdl/clm_lut_ram.sv
// ----------------------------------------------------------------------------
// clm_lut_ram
// color table store: one write port, two registered read ports
// ----------------------------------------------------------------------------
`default_nettype none

module clm_lut_ram (
    input  wire                           i_clk,
    input  wire clm_pkg::t_wr_req         i_wr,
    input  wire                           i_rd_en,
    input  wire [clm_pkg::ADDR_W-1:0]     i_rd_addr_a,
    input  wire [clm_pkg::ADDR_W-1:0]     i_rd_addr_b,
    output logic [clm_pkg::PIX_W-1:0]     o_rd_data_a,
    output logic [clm_pkg::PIX_W-1:0]     o_rd_data_b
);

    logic [clm_pkg::PIX_W-1:0] r_mem [2**clm_pkg::ADDR_W];
    logic [clm_pkg::PIX_W-1:0] r_rd_data_a;
    logic [clm_pkg::PIX_W-1:0] r_rd_data_b;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // read data holds while the pipeline is stalled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data_a <= r_mem[i_rd_addr_a];
            r_rd_data_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_data_a;
    assign o_rd_data_b = r_rd_data_b;

endmodule

`default_nettype wire

FILE: hdl/color_lut_3d_mapper.sv
// ----------------------------------------------------------------------------
// color_lut_3d_mapper
// pipeline: table read, weighted sum, output register; throughput: one item
//   per cycle unless the output stalls. The table's two read ports serve
//   both grid corners of a pixel together while the write port takes loads
// reset: synchronous, active low; clears pipeline valids and lut_enable,
//   the table itself holds whatever was loaded, no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module color_lut_3d_mapper (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    clm_in_if.sink                         i_item,
    clm_out_if.source                      o_item,
    input  wire                            psel,
    input  wire                            penable,
    input  wire                            pwrite,
    input  wire [clm_pkg::PADDR_W-1:0]     paddr,
    input  wire [31:0]                     pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    logic                            r_lut_enable;
    logic [clm_pkg::REG_IDX_W-1:0]   w_reg_idx;
    logic                            w_cfg_wr;

    assign w_reg_idx = paddr[clm_pkg::PADDR_W-1:2];
    assign w_cfg_wr  = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lut_enable <= 1'b0;
        end else if (w_cfg_wr && (w_reg_idx == clm_pkg::REG_LUT_ENABLE)) begin
            r_lut_enable <= pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_reg_idx)
            clm_pkg::REG_LUT_ENABLE: prdata[0] = r_lut_enable;
            default:                 prdata    = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // flow control: every stage moves together whenever the output
    // register is empty or being drained, so ready never waits on idle
    // ------------------------------------------------------------------
    logic w_adv;
    logic w_acc;
    logic r_out_vld;

    assign w_adv        = !r_out_vld || o_item.ready;
    assign w_acc        = i_item.valid && w_adv;
    assign i_item.ready = w_adv;

    // ------------------------------------------------------------------
    // stage 0: grid cells and the two corner addresses, straight off the
    // input item; loads go to the write port at the accepting edge
    // ------------------------------------------------------------------
    clm_pkg::t_pixel            w_in_pix;
    clm_pkg::t_grid             w_grid [clm_pkg::NUM_CH];
    logic [clm_pkg::ADDR_W-1:0] w_addr_lo;
    logic [clm_pkg::ADDR_W-1:0] w_addr_hi;
    clm_pkg::t_wr_req           w_wr;

    assign w_in_pix[clm_pkg::CH_RED]   = i_item.payload.red_in;
    assign w_in_pix[clm_pkg::CH_GREEN] = i_item.payload.green_in;
    assign w_in_pix[clm_pkg::CH_BLUE]  = i_item.payload.blue_in;

    always_comb begin
        for (int c = 0; c < clm_pkg::NUM_CH; c++) begin
            w_grid[c] = clm_pkg::grid_of(w_in_pix[c]);
        end
    end

    // all-low and all-high grid corners
    assign w_addr_lo = clm_pkg::lut_addr(w_grid[clm_pkg::CH_RED].lo,
                                         w_grid[clm_pkg::CH_GREEN].lo,
                                         w_grid[clm_pkg::CH_BLUE].lo);
    assign w_addr_hi = clm_pkg::lut_addr(w_grid[clm_pkg::CH_RED].hi,
                                         w_grid[clm_pkg::CH_GREEN].hi,
                                         w_grid[clm_pkg::CH_BLUE].hi);

    // a load written at this edge is seen by a pixel read at the next one,
    // and no two items share an edge, so no forwarding path is needed
    assign w_wr.en   = w_acc && (i_item.payload.operation == clm_pkg::OP_LOAD);
    assign w_wr.addr = i_item.payload.entry_index;
    assign w_wr.data = w_in_pix;

    logic [clm_pkg::PIX_W-1:0] w_rd_lo;
    logic [clm_pkg::PIX_W-1:0] w_rd_hi;

    clm_lut_ram u_lut_ram (
        .i_clk       (i_clk),
        .i_wr        (w_wr),
        .i_rd_en     (w_adv),
        .i_rd_addr_a (w_addr_lo),
        .i_rd_addr_b (w_addr_hi),
        .o_rd_data_a (w_rd_lo),
        .o_rd_data_b (w_rd_hi)
    );

    // ------------------------------------------------------------------
    // stage 1: table read in flight; pixel and weights ride alongside.
    // loads end here, only pixel items carry a valid onward
    // ------------------------------------------------------------------
    logic                                r_s1_vld;
    clm_pkg::t_pixel                     r_s1_pix;
    logic [clm_pkg::NUM_CH-1:0][clm_pkg::CH_W-1:0] r_s1_m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_adv) begin
            r_s1_vld <= w_acc && (i_item.payload.operation == clm_pkg::OP_MAP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_pix <= w_in_pix;
            for (int c = 0; c < clm_pkg::NUM_CH; c++) begin
                r_s1_m[c] <= w_grid[c].m;
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 2: weighted sum lo*(255-m) + hi*m per channel
    // ------------------------------------------------------------------
    clm_pkg::t_pixel                                 w_lo_pix;
    clm_pkg::t_pixel                                 w_hi_pix;
    logic [clm_pkg::NUM_CH-1:0][clm_pkg::SUM_W-1:0]  n_s2_sum;
    logic [clm_pkg::NUM_CH-1:0][clm_pkg::SUM_W-1:0]  r_s2_sum;
    logic                                            r_s2_vld;
    clm_pkg::t_pixel                                 r_s2_pix;

    assign w_lo_pix = w_rd_lo;
    assign w_hi_pix = w_rd_hi;

    // sum never exceeds 255*255, so it fits the product width
    always_comb begin
        for (int c = 0; c < clm_pkg::NUM_CH; c++) begin
            n_s2_sum[c] = clm_pkg::SUM_W'(w_lo_pix[c] * (clm_pkg::CH_MAX - r_s1_m[c]))
                        + clm_pkg::SUM_W'(w_hi_pix[c] * r_s1_m[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (w_adv) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s2_pix <= r_s1_pix;
            r_s2_sum <= n_s2_sum;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: divide by 255 (truncating) or pass the pixel, into the
    // output register
    // ------------------------------------------------------------------
    clm_pkg::t_pixel n_out_pix;
    clm_pkg::t_pixel r_out_pix;

    always_comb begin
        for (int c = 0; c < clm_pkg::NUM_CH; c++) begin
            n_out_pix[c] = r_lut_enable ? clm_pkg::div255(r_s2_sum[c]) : r_s2_pix[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_pix <= n_out_pix;
        end
    end

    assign o_item.valid             = r_out_vld;
    assign o_item.payload.red_out   = r_out_pix[clm_pkg::CH_RED];
    assign o_item.payload.green_out = r_out_pix[clm_pkg::CH_GREEN];
    assign o_item.payload.blue_out  = r_out_pix[clm_pkg::CH_BLUE];

endmodule

`default_nettype wire

FILE: hdl/clm_checker.sv
// ----------------------------------------------------------------------------
// clm_checker
// port-level checks of the color table mapper, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module clm_checker (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          i_in_ready,
    input wire                          i_out_valid,
    input wire                          i_out_ready,
    input wire [clm_pkg::PIX_W-1:0]     i_out_data
);

    // the output register never blocks input while it is empty
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output register");

    // a stalled output stalls the input side too
    a_stall_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |-> !i_in_ready)
        else $error("input accepted while output stalled");

    // reset empties the pipeline
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    // a waiting result keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("pending result changed or dropped");

endmodule

bind color_lut_3d_mapper clm_checker u_clm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_item.valid),
    .i_out_ready (o_item.ready),
    .i_out_data  (o_item.payload)
);

`default_nettype wire
